// ===== hw/rtl/wmad_pkg.sv =====
// Package with shared types and constants for the word multiply-add-divide unit.
`default_nettype none
package wmad_pkg;
  localparam int WordBits = 32;
  localparam int ValBits  = 2 * WordBits;
  localparam int OpBits   = 3;

  typedef enum logic [OpBits-1:0] {
    OP_MUL        = 3'd0,
    OP_MULADD     = 3'd1,
    OP_MULADD2    = 3'd2,
    OP_MULDIV     = 3'd3,
    OP_MULADDDIV  = 3'd4,
    OP_MULADDMOD  = 3'd5,
    OP_TWOWORDDIV = 3'd6,
    OP_DIV32      = 3'd7
  } wmad_op_t;

  // Control that travels alongside the division row.
  typedef struct packed {
    logic     vld;
    wmad_op_t op;
    logic     dz;
  } wmad_ctl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/wmad_front.sv =====
// Front stages: registered 32x32 product, then addend sums and divisor check.
`default_nettype none
module wmad_front import wmad_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic [OpBits-1:0]   in_op,
  input  wire logic [WordBits-1:0] in_a,
  input  wire logic [WordBits-1:0] in_b,
  input  wire logic [WordBits-1:0] in_c,
  input  wire logic [WordBits-1:0] in_d,
  input  wire logic [WordBits-1:0] in_dv,
  output wmad_ctl_t                ctl_o,
  output logic [ValBits-1:0]       val_o,
  output logic [WordBits-1:0]      dv_o
);
  wmad_ctl_t             ctl1_r, ctl2_r;
  logic [ValBits-1:0]    prod_r, val2_r;
  logic [WordBits-1:0]   a1_r, b1_r, c1_r, d1_r, dv1_r, dv2_r;
  logic [ValBits-1:0]    val_nxt;

  always_comb begin
    case (ctl1_r.op)
      OP_MUL, OP_MULDIV:                      val_nxt = prod_r;
      OP_MULADD, OP_MULADDDIV, OP_MULADDMOD:  val_nxt = prod_r + {{WordBits{1'b0}}, c1_r};
      OP_MULADD2: val_nxt = prod_r + {{WordBits{1'b0}}, c1_r} + {{WordBits{1'b0}}, d1_r};
      OP_TWOWORDDIV:                          val_nxt = {a1_r, b1_r};
      default:                                val_nxt = {{WordBits{1'b0}}, a1_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl2_r.vld <= 1'b0;
    end else if (en) begin
      ctl1_r.vld <= in_vld;
      ctl2_r.vld <= ctl1_r.vld;
    end
    if (en) begin
      ctl1_r.op <= wmad_op_t'(in_op);
      ctl1_r.dz <= 1'b0;
      prod_r    <= ValBits'(in_a) * ValBits'(in_b);
      a1_r <= in_a; b1_r <= in_b; c1_r <= in_c; d1_r <= in_d; dv1_r <= in_dv;
      ctl2_r.op <= ctl1_r.op;
      ctl2_r.dz <= (ctl1_r.op >= OP_MULDIV) && (dv1_r == '0);
      val2_r    <= val_nxt;
      dv2_r     <= dv1_r;
    end
  end

  assign ctl_o = ctl2_r;
  assign val_o = val2_r;
  assign dv_o  = dv2_r;
endmodule
`default_nettype wire

// ===== hw/rtl/wmad_div_cell.sv =====
// One restoring-division cell: produces one quotient bit and hands on to the next cell.
`default_nettype none
module wmad_div_cell import wmad_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire wmad_ctl_t           ctl_i,
  input  wire logic [WordBits:0]   rem_i,
  input  wire logic [ValBits-1:0]  quo_i,
  input  wire logic [WordBits-1:0] dv_i,
  output wmad_ctl_t                ctl_o,
  output logic [WordBits:0]        rem_o,
  output logic [ValBits-1:0]       quo_o,
  output logic [WordBits-1:0]      dv_o
);
  // The quotient register doubles as the dividend shift register.
  logic [WordBits+1:0] trial;
  logic [WordBits:0]   shifted;
  wmad_ctl_t           ctl_r;
  logic [WordBits:0]   rem_r;
  logic [ValBits-1:0]  quo_r;
  logic [WordBits-1:0] dv_r;

  assign shifted = {rem_i[WordBits-1:0], quo_i[ValBits-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dv_i};

  always_ff @(posedge clk) begin
    if (!rst_n) ctl_r.vld <= 1'b0;
    else if (en) ctl_r.vld <= ctl_i.vld;
    if (en) begin
      ctl_r.op <= ctl_i.op;
      ctl_r.dz <= ctl_i.dz;
      dv_r     <= dv_i;
      if (!trial[WordBits+1]) begin
        rem_r <= trial[WordBits:0];
        quo_r <= {quo_i[ValBits-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_i[ValBits-2:0], 1'b0};
      end
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign quo_o = quo_r;
  assign dv_o  = dv_r;
endmodule
`default_nettype wire

// ===== hw/rtl/word_multiply_add_divide_unit_core.sv =====
// Top level of the word multiply-add-divide unit: front stages, division cell row, output skid.
//
//  Channel | Direction | Ports                                                   | Handshake
//  in      | input     | in_req_type, in_op_a..in_op_d, in_divisor               | in_valid/in_ready
//  out     | output    | out_result_low/high, out_div_by_zero, out_quotient_overflow | out_valid/out_ready
//
// One transaction per cycle is accepted while the pipeline is not stalled; each
// result passes through two front stages, 64 division cells and one output register.
// The whole pipeline advances together; it stalls only when the output register
// is full and not taken, and a bubble in the pipe still moves.
// Reset is synchronous and clears every valid bit; there is no clearing pass.
`default_nettype none
module word_multiply_add_divide_unit_core import wmad_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [OpBits-1:0]   in_req_type,
  input  wire logic [WordBits-1:0] in_op_a,
  input  wire logic [WordBits-1:0] in_op_b,
  input  wire logic [WordBits-1:0] in_op_c,
  input  wire logic [WordBits-1:0] in_op_d,
  input  wire logic [WordBits-1:0] in_divisor,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [WordBits-1:0]      out_result_low,
  output logic [WordBits-1:0]      out_result_high,
  output logic                     out_div_by_zero,
  output logic                     out_quotient_overflow
);
  localparam int NCells = ValBits;

  logic                en;
  wmad_ctl_t           ctl   [NCells+1];
  logic [WordBits:0]   rem   [NCells+1];
  logic [ValBits-1:0]  quo   [NCells+1];
  logic [WordBits-1:0] dv    [NCells+1];
  logic [ValBits-1:0]  front_val;

  logic                out_vld_r;
  logic [WordBits-1:0] lo_r, hi_r, lo_nxt, hi_nxt;
  logic                dz_r, ov_r, dz_nxt, ov_nxt;

  // Pipeline moves whenever the output slot is free or being emptied.
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  wmad_front u_front (
    .clk, .rst_n, .en,
    .in_vld (in_valid && in_ready),
    .in_op  (in_req_type),
    .in_a   (in_op_a), .in_b (in_op_b), .in_c (in_op_c), .in_d (in_op_d),
    .in_dv  (in_divisor),
    .ctl_o  (ctl[0]),
    .val_o  (front_val),
    .dv_o   (dv[0])
  );

  assign rem[0] = '0;
  assign quo[0] = front_val;

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    wmad_div_cell u_cell (
      .clk, .rst_n, .en,
      .ctl_i (ctl[i]), .rem_i (rem[i]), .quo_i (quo[i]), .dv_i (dv[i]),
      .ctl_o (ctl[i+1]), .rem_o (rem[i+1]), .quo_o (quo[i+1]), .dv_o (dv[i+1])
    );
  end

  // The multiply codes need the undivided value, so it travels in a parallel
  // register line beside the cells.
  logic [ValBits-1:0] val_line [NCells+1];
  assign val_line[0] = front_val;
  for (genvar i = 0; i < NCells; i++) begin : g_val
    logic [ValBits-1:0] v_r;
    always_ff @(posedge clk) begin
      if (en) v_r <= val_line[i];
    end
    assign val_line[i+1] = v_r;
  end

  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    dz_nxt = 1'b0;
    ov_nxt = 1'b0;
    case (ctl[NCells].op)
      OP_MUL, OP_MULADD, OP_MULADD2: begin
        lo_nxt = val_line[NCells][WordBits-1:0];
        hi_nxt = val_line[NCells][ValBits-1:WordBits];
      end
      default: begin
        if (ctl[NCells].dz) begin
          dz_nxt = 1'b1;
        end else begin
          lo_nxt = rem[NCells][WordBits-1:0];
          if (ctl[NCells].op != OP_MULADDMOD) begin
            hi_nxt = quo[NCells][WordBits-1:0];
            ov_nxt = |quo[NCells][ValBits-1:WordBits];
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (en) out_vld_r <= ctl[NCells].vld;
    if (en) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
      dz_r <= dz_nxt;
      ov_r <= ov_nxt;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_result_low        = lo_r;
  assign out_result_high       = hi_r;
  assign out_div_by_zero       = dz_r;
  assign out_quotient_overflow = ov_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_low))
    else $error("result changed while stalled");
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_div_by_zero && out_quotient_overflow))
    else $error("both flags set");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_by_zero |-> out_result_low == '0 && out_result_high == '0)
    else $error("division by zero gave non-zero result");
endmodule
`default_nettype wire
